FILE: rtl/mkrs_pkg.sv
// shared constants and controller/datapath interface types of the row sorter
package mkrs_pkg;

  localparam int MAX_ROWS       = 64;
  localparam int MAX_KEYS       = 4;
  localparam int NUM_KEY_FIELDS = 4;
  localparam int KEY_W          = 64;
  localparam int ROW_W          = $clog2(MAX_ROWS);
  localparam int CNT_W          = $clog2(MAX_ROWS + 1);
  localparam int ROWKEYS_W      = KEY_W * MAX_KEYS;
  localparam int SRC_W          = 6;
  localparam int KC_W           = 3;
  localparam int MASK_W         = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DESC_MASK = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;       // input request taken this cycle
    logic clear_batch;  // batch done, reset row count and overflow flag
    logic init_i;
    logic rd_row;       // read keys of row i, j starts at i
    logic ld_row;
    logic rd_ord;       // read order entry j-1
    logic rd_key;       // read keys of that entry
    logic cmp;
    logic shift;        // move order entry up one place
    logic place;        // drop row i into slot j
    logic init_p;
    logic next_p;
    logic emit_rd;
    logic out_load;
    logic out_pop;
  } mkrs_cmd_t;

  typedef struct packed {
    logic rows_zero;
    logic j_zero;
    logic j_is_one;
    logic i_last;
    logic p_last;
    logic precedes;
  } mkrs_status_t;

endpackage

FILE: rtl/mkrs_ram.sv
// generic single write port ram with registered read
module mkrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mkrs_dp.sv
// datapath: key and order memories, loop counters, key compare, output register
module mkrs_dp import mkrs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mkrs_cmd_t                    cmd_i,
  output mkrs_status_t                 status_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [KEY_W-1:0]      key_first_i,
  input  logic signed [KEY_W-1:0]      key_second_i,
  input  logic signed [KEY_W-1:0]      key_third_i,
  input  logic signed [KEY_W-1:0]      key_fourth_i,
  input  logic                         row_present_i,
  output logic                         out_valid_o,
  output logic [SRC_W-1:0]             source_index_o,
  output logic                         last_of_run_o,
  output logic                         overflowed_o
);

  logic [CNT_W-1:0]     rows_q, rows_d;
  logic                 ovf_q, ovf_d;
  logic [ROW_W-1:0]     i_q, i_d;
  logic [ROW_W-1:0]     j_q, j_d;
  logic [ROW_W-1:0]     p_q, p_d;
  logic                 out_valid_q, out_valid_d;
  logic [KC_W-1:0]      key_count_q;
  logic [MASK_W-1:0]    desc_mask_q;

  logic [ROWKEYS_W-1:0] cur_keys_q;
  logic [ROW_W-1:0]     prev_idx_q;
  logic [MAX_KEYS-1:0]  lt_q, lt_d;
  logic [MAX_KEYS-1:0]  eq_q, eq_d;
  logic [ROW_W-1:0]     out_idx_q;
  logic                 out_last_q;
  logic                 out_ovf_q;

  logic signed [KEY_W-1:0] key_in [NUM_KEY_FIELDS];
  logic [ROWKEYS_W-1:0] key_wdata;
  logic [ROWKEYS_W-1:0] key_rdata;
  logic                 key_we;
  logic [ROW_W-1:0]     key_raddr;
  logic                 ord_we;
  logic [ROW_W-1:0]     ord_wdata;
  logic [ROW_W-1:0]     ord_raddr;
  logic [ROW_W-1:0]     ord_rdata;
  logic                 room;
  logic [KC_W-1:0]      nkeys;
  logic                 goes_first;
  logic                 found;

  assign key_in[0] = key_first_i;
  assign key_in[1] = key_second_i;
  assign key_in[2] = key_third_i;
  assign key_in[3] = key_fourth_i;

  always_comb begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      key_wdata[k*KEY_W +: KEY_W] = key_in[k];
    end
  end

  assign room      = rows_q < CNT_W'(MAX_ROWS);
  assign key_we    = cmd_i.accept && row_present_i && room;
  assign key_raddr = cmd_i.rd_key ? ord_rdata : i_q;
  assign ord_we    = cmd_i.shift || cmd_i.place;
  assign ord_wdata = cmd_i.shift ? prev_idx_q : i_q;
  assign ord_raddr = cmd_i.emit_rd ? p_q : (j_q - ROW_W'(1));

  mkrs_ram #(
    .WIDTH (ROWKEYS_W),
    .DEPTH (MAX_ROWS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (rows_q[ROW_W-1:0]),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  mkrs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (j_q),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // key count clamped into 1..MAX_KEYS
  always_comb begin
    priority if (key_count_q == KC_W'(0)) begin
      nkeys = KC_W'(1);
    end else if (key_count_q > KC_W'(MAX_KEYS)) begin
      nkeys = KC_W'(MAX_KEYS);
    end else begin
      nkeys = key_count_q;
    end
  end

  // per-key signed compare of row i against the row read from the order slot
  always_comb begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      lt_d[k] = $signed(cur_keys_q[k*KEY_W +: KEY_W]) < $signed(key_rdata[k*KEY_W +: KEY_W]);
      eq_d[k] = cur_keys_q[k*KEY_W +: KEY_W] == key_rdata[k*KEY_W +: KEY_W];
    end
  end

  // first differing active key decides, equal rows keep arrival order
  always_comb begin
    goes_first = 1'b0;
    found      = 1'b0;
    for (int k = 0; k < MAX_KEYS; k++) begin
      if (!found && (KC_W'(k) < nkeys) && !eq_q[k]) begin
        goes_first = desc_mask_q[k] ? !lt_q[k] : lt_q[k];
        found      = 1'b1;
      end
    end
  end

  always_comb begin
    rows_d      = rows_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    out_valid_d = out_valid_q;
    if (cmd_i.accept && row_present_i) begin
      if (room) begin
        rows_d = rows_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.clear_batch) begin
      rows_d = '0;
      ovf_d  = 1'b0;
    end
    if (cmd_i.init_i) begin
      i_d = '0;
    end
    if (cmd_i.rd_row) begin
      j_d = i_q;
    end
    if (cmd_i.shift) begin
      j_d = j_q - ROW_W'(1);
    end
    if (cmd_i.place) begin
      i_d = i_q + ROW_W'(1);
    end
    if (cmd_i.init_p) begin
      p_d = '0;
    end
    if (cmd_i.next_p) begin
      p_d = p_q + ROW_W'(1);
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
      key_count_q <= KC_W'(1);
      desc_mask_q <= '0;
    end else begin
      rows_q      <= rows_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == REG_KEY_COUNT)) begin
        key_count_q <= cfg_data_i[KC_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_DESC_MASK)) begin
        desc_mask_q <= cfg_data_i[MASK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_row) begin
      cur_keys_q <= key_rdata;
    end
    if (cmd_i.rd_key) begin
      prev_idx_q <= ord_rdata;
    end
    if (cmd_i.cmp) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
    if (cmd_i.out_load) begin
      out_idx_q  <= ord_rdata;
      out_last_q <= status_o.p_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign status_o.rows_zero = rows_q == '0;
  assign status_o.j_zero    = j_q == '0;
  assign status_o.j_is_one  = j_q == ROW_W'(1);
  assign status_o.i_last    = (CNT_W'(i_q) + CNT_W'(1)) == rows_q;
  assign status_o.p_last    = (CNT_W'(p_q) + CNT_W'(1)) == rows_q;
  assign status_o.precedes  = goes_first;

  assign out_valid_o    = out_valid_q;
  assign source_index_o = SRC_W'(out_idx_q);
  assign last_of_run_o  = out_last_q;
  assign overflowed_o   = out_ovf_q;

  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= CNT_W'(MAX_ROWS))
    else $error("row count above capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (rows_q == CNT_W'(MAX_ROWS)))
    else $error("overflow flagged with free row slots");

  a_rd_ord_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_ord |-> (j_q != '0))
    else $error("order read below the first slot");

  a_shift_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (j_q != '0) && (j_q <= i_q))
    else $error("order shift outside the sorted prefix");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("output register overwritten before it was taken");

endmodule

FILE: rtl/mkrs_ctrl.sv
// controller: batch collection, insertion sort sequencing and result emission
module mkrs_ctrl import mkrs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         final_row_i,
  output logic         in_stall_o,
  input  logic         out_stall_i,
  input  mkrs_status_t status_i,
  output mkrs_cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_START     = 12'b000000000010,
    S_RD_ROW    = 12'b000000000100,
    S_LD_ROW    = 12'b000000001000,
    S_RD_ORD    = 12'b000000010000,
    S_RD_KEY    = 12'b000000100000,
    S_CMP       = 12'b000001000000,
    S_DECIDE    = 12'b000010000000,
    S_PLACE     = 12'b000100000000,
    S_EMIT_RD   = 12'b001000000000,
    S_EMIT_LD   = 12'b010000000000,
    S_EMIT_WAIT = 12'b100000000000
  } mkrs_state_e;

  mkrs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (final_row_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (status_i.rows_zero) begin
          cmd_o.clear_batch = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.init_i = 1'b1;
          state_d      = S_RD_ROW;
        end
      end
      S_RD_ROW: begin
        cmd_o.rd_row = 1'b1;
        state_d      = S_LD_ROW;
      end
      S_LD_ROW: begin
        cmd_o.ld_row = 1'b1;
        state_d      = status_i.j_zero ? S_PLACE : S_RD_ORD;
      end
      S_RD_ORD: begin
        cmd_o.rd_ord = 1'b1;
        state_d      = S_RD_KEY;
      end
      S_RD_KEY: begin
        cmd_o.rd_key = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.precedes) begin
          cmd_o.shift = 1'b1;
          state_d     = status_i.j_is_one ? S_PLACE : S_RD_ORD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        if (status_i.i_last) begin
          cmd_o.init_p = 1'b1;
          state_d      = S_EMIT_RD;
        end else begin
          state_d = S_RD_ROW;
        end
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (!out_stall_i) begin
          cmd_o.out_pop = 1'b1;
          if (status_i.p_last) begin
            cmd_o.clear_batch = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.next_p = 1'b1;
            state_d      = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  a_place_sorting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |-> !status_i.rows_zero)
    else $error("sort step running on an empty batch");

endmodule

FILE: rtl/multi_key_row_sorter_core.sv
// top level of the stable multi-key row sorter
//
// channel   dir   handshake                 payload
// in        in    in_valid_i / in_stall_o   key_first_i..key_fourth_i, final_row_i, row_present_i
// out       out   out_valid_o / out_stall_i source_index_o, last_of_run_o, overflowed_o
// cfg       in    cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a row request is taken while the block is idle; the final request starts the sort
// sort of n rows: at most n(n-1)/2 key compares, each reading one row through the
// single read port of the key memory
// results are emitted one at a time, each held through any output stall; input stalls
// from the final request until the last result of the batch is taken
// reset clears the row count and overflow flag and sets key count 1, mask 0; no memory clearing pass
module multi_key_row_sorter_core import mkrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [KEY_W-1:0] key_first_i,
  input  logic signed [KEY_W-1:0] key_second_i,
  input  logic signed [KEY_W-1:0] key_third_i,
  input  logic signed [KEY_W-1:0] key_fourth_i,
  input  logic                    final_row_i,
  input  logic                    row_present_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SRC_W-1:0]        source_index_o,
  output logic                    last_of_run_o,
  output logic                    overflowed_o
);

  mkrs_cmd_t    cmd;
  mkrs_status_t status;

  mkrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .final_row_i (final_row_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mkrs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .key_first_i    (key_first_i),
    .key_second_i   (key_second_i),
    .key_third_i    (key_third_i),
    .key_fourth_i   (key_fourth_i),
    .row_present_i  (row_present_i),
    .out_valid_o    (out_valid_o),
    .source_index_o (source_index_o),
    .last_of_run_o  (last_of_run_o),
    .overflowed_o   (overflowed_o)
  );

  a_no_input_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

endmodule

FILE: tb/mkrs_sort_check.sv
// order checker for the row sorter: tracks rows and registers, predicts sorted indices
`timescale 1ns / 100ps

module mkrs_sort_check import mkrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [KEY_W-1:0] key_first_i,
  input  logic signed [KEY_W-1:0] key_second_i,
  input  logic signed [KEY_W-1:0] key_third_i,
  input  logic signed [KEY_W-1:0] key_fourth_i,
  input  logic                    final_row_i,
  input  logic                    row_present_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [SRC_W-1:0]        source_index_i,
  input  logic                    last_of_run_i,
  input  logic                    overflowed_i,
  output int                      mismatch_count_o,
  output int                      pending_count_o
);

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic             last;
    logic             ovf;
  } sorted_slot_t;

  logic signed [KEY_W-1:0] row_keys [MAX_ROWS][MAX_KEYS];
  int                      rows_held;
  logic                    rows_dropped;
  logic [KC_W-1:0]         key_count_q;
  logic [MASK_W-1:0]       desc_mask_q;
  sorted_slot_t            order_q[$];
  int                      mismatches = 0;

  // strict precedence only, so equal rows stay in arrival order
  function automatic bit row_precedes(input int a, input int b, input int nkeys);
    for (int k = 0; k < nkeys; k++) begin
      if (row_keys[a][k] != row_keys[b][k]) begin
        if (desc_mask_q[k])
          return row_keys[a][k] > row_keys[b][k];
        return row_keys[a][k] < row_keys[b][k];
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_order();
    int perm [MAX_ROWS];
    int nkeys;
    int j;
    sorted_slot_t slot;
    if (key_count_q == 0)
      nkeys = 1;
    else if (key_count_q > MAX_KEYS)
      nkeys = MAX_KEYS;
    else
      nkeys = int'(key_count_q);
    for (int i = 0; i < rows_held; i++) begin
      j = i;
      while (j > 0 && row_precedes(i, perm[j-1], nkeys)) begin
        perm[j] = perm[j-1];
        j--;
      end
      perm[j] = i;
    end
    for (int i = 0; i < rows_held; i++) begin
      slot.src  = SRC_W'(perm[i]);
      slot.last = (i == rows_held - 1);
      slot.ovf  = rows_dropped;
      order_q.insert(order_q.size(), slot);
    end
    rows_held    = 0;
    rows_dropped = 1'b0;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_slot_t want;
    if (!rst_ni) begin
      rows_held    = 0;
      rows_dropped = 1'b0;
      key_count_q  = KC_W'(1);
      desc_mask_q  = '0;
      order_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (order_q.size() == 0) begin
          note_mismatch($sformatf("no result expected, got src=%0d last=%0b ovf=%0b",
                                  source_index_i, last_of_run_i, overflowed_i));
        end else begin
          want = order_q.pop_front();
          if (source_index_i !== want.src || last_of_run_i !== want.last ||
              overflowed_i !== want.ovf)
            note_mismatch($sformatf("expected src=%0d last=%0b ovf=%0b, got src=%0d last=%0b ovf=%0b",
                                    want.src, want.last, want.ovf,
                                    source_index_i, last_of_run_i, overflowed_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_KEY_COUNT)
          key_count_q = cfg_data_i[KC_W-1:0];
        else if (cfg_idx_i == REG_DESC_MASK)
          desc_mask_q = cfg_data_i[MASK_W-1:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (row_present_i) begin
          if (rows_held < MAX_ROWS) begin
            row_keys[rows_held][0] = key_first_i;
            row_keys[rows_held][1] = key_second_i;
            row_keys[rows_held][2] = key_third_i;
            row_keys[rows_held][3] = key_fourth_i;
            rows_held++;
          end else begin
            rows_dropped = 1'b1;
          end
        end
        if (final_row_i)
          predict_order();
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= order_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// testbench top for the row sorter: clock, reset, request stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import mkrs_pkg::*;

  localparam int TOTAL_ITEMS   = 370;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 1000;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [KEY_W-1:0] key_first;
  logic signed [KEY_W-1:0] key_second;
  logic signed [KEY_W-1:0] key_third;
  logic signed [KEY_W-1:0] key_fourth;
  logic                    final_row;
  logic                    row_present;
  logic                    out_valid;
  logic                    out_stall;
  logic [SRC_W-1:0]        source_index;
  logic                    last_of_run;
  logic                    overflowed;

  logic recv_stall = 1'b0;
  logic hold_stall = 1'b0;
  bit   steady_send = 1'b0;
  bit   steady_recv = 1'b0;
  bit   hold_go = 1'b0;
  int   mismatch_count;
  int   pending_count;
  int   items_sent = 0;
  int   cycle_count = 0;

  assign out_stall = recv_stall | hold_stall;

  multi_key_row_sorter_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .key_first_i    (key_first),
    .key_second_i   (key_second),
    .key_third_i    (key_third),
    .key_fourth_i   (key_fourth),
    .final_row_i    (final_row),
    .row_present_i  (row_present),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .source_index_o (source_index),
    .last_of_run_o  (last_of_run),
    .overflowed_o   (overflowed)
  );

  mkrs_sort_check sort_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .key_first_i      (key_first),
    .key_second_i     (key_second),
    .key_third_i      (key_third),
    .key_fourth_i     (key_fourth),
    .final_row_i      (final_row),
    .row_present_i    (row_present),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .source_index_i   (source_index),
    .last_of_run_i    (last_of_run),
    .overflowed_i     (overflowed),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random hold-off before each result
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = steady_recv ? 0 : $urandom_range(0, 15);
      if (wait_cycles > 0) begin
        recv_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      recv_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // one long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_stall <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_stall <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // style 0 wide, 1 small values for ties, 2 extremes, 3 mixed per key
  function automatic logic signed [KEY_W-1:0] pick_key(input int style);
    int kind;
    kind = (style == 3) ? $urandom_range(0, 2) : style;
    case (kind)
      0: return {$urandom, $urandom};
      1: return KEY_W'(int'($urandom_range(0, 4)) - 2);
      default: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // request stays valid from here until taken
  task automatic offer_row(input logic signed [KEY_W-1:0] k0, input logic signed [KEY_W-1:0] k1,
                           input logic signed [KEY_W-1:0] k2, input logic signed [KEY_W-1:0] k3,
                           input logic fin, input logic present);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    key_first   <= k0;
    key_second  <= k1;
    key_third   <= k2;
    key_fourth  <= k3;
    final_row   <= fin;
    row_present <= present;
    do @(posedge clk); while (in_stall);
    if (present || fin)
      items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_batch(input int n_rows, input bit close_with_row);
    int style;
    for (int r = 0; r < n_rows; r++) begin
      if ($urandom_range(0, 11) == 0)
        offer_row(pick_key(0), pick_key(0), pick_key(0), pick_key(0), 1'b0, 1'b0);
      style = $urandom_range(0, 3);
      offer_row(pick_key(style), pick_key(style), pick_key(style), pick_key(style),
                close_with_row && (r == n_rows - 1), 1'b1);
    end
    if (!close_with_row || n_rows == 0)
      offer_row(pick_key(0), pick_key(0), pick_key(0), pick_key(0), 1'b1, 1'b0);
  endtask

  initial begin
    int batch_no;
    int n_rows;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    key_first   = '0;
    key_second  = '0;
    key_third   = '0;
    key_fourth  = '0;
    final_row   = 1'b0;
    row_present = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: one ascending key, equal minimum rows keep arrival order
    offer_row(KEY_MAX, '1, '0, KEY_MIN, 1'b0, 1'b1);
    offer_row(KEY_MIN, '0, KEY_MAX, '1, 1'b0, 1'b1);
    offer_row('0, KEY_MAX, '1, '0, 1'b0, 1'b1);
    offer_row('1, KEY_MIN, '0, KEY_MAX, 1'b0, 1'b1);
    offer_row(KEY_MIN, KEY_MAX, KEY_MIN, '0, 1'b1, 1'b1);
    // idle request, then an empty batch
    offer_row('1, '1, '1, '1, 1'b0, 1'b0);
    offer_row('0, '0, '0, '0, 1'b1, 1'b0);

    // all four keys, mixed directions, closed by a request without a row
    settle();
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(4));
    write_reg(REG_DESC_MASK, CFG_DATA_W'(4'b1010));
    offer_row(64'sd5, 64'sd3, KEY_MIN, 64'sd1, 1'b0, 1'b1);
    offer_row(64'sd5, 64'sd3, KEY_MAX, 64'sd2, 1'b0, 1'b1);
    offer_row(64'sd5, -64'sd7, '0, 64'sd3, 1'b0, 1'b1);
    offer_row(64'sd5, 64'sd3, KEY_MIN, 64'sd2, 1'b0, 1'b1);
    offer_row(64'sd5, 64'sd3, KEY_MIN, 64'sd1, 1'b0, 1'b1);
    offer_row('0, '0, '0, '0, 1'b1, 1'b0);

    // key count zero acts as one, first key descending
    settle();
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(0));
    write_reg(REG_DESC_MASK, CFG_DATA_W'(4'b0001));
    offer_row(-64'sd2, 64'sd9, '0, '0, 1'b0, 1'b1);
    offer_row(-64'sd2, -64'sd9, '0, '0, 1'b0, 1'b1);
    offer_row(KEY_MAX, '0, '0, '0, 1'b0, 1'b1);
    offer_row(-64'sd2, '0, '0, '0, 1'b1, 1'b1);

    // oversized key count clamps, spare indexes ignored, registers change mid-batch
    settle();
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(15));
    write_reg(REG_DESC_MASK, CFG_DATA_W'(4'b1111));
    write_reg(REG_SPARE_A, CFG_DATA_W'(4'b1111));
    write_reg(REG_SPARE_B, CFG_DATA_W'(0));
    offer_row(pick_key(1), pick_key(1), pick_key(1), pick_key(1), 1'b0, 1'b1);
    offer_row(pick_key(1), pick_key(1), pick_key(1), pick_key(1), 1'b0, 1'b1);
    offer_row(pick_key(1), pick_key(1), pick_key(1), pick_key(1), 1'b0, 1'b1);
    settle();
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(2));
    write_reg(REG_DESC_MASK, CFG_DATA_W'(4'b0010));
    offer_row(pick_key(1), pick_key(1), pick_key(1), pick_key(1), 1'b1, 1'b1);

    batch_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      steady_send = ($urandom_range(0, 5) == 0);
      steady_recv = ($urandom_range(0, 5) == 0);
      if (batch_no == 4)
        hold_go = 1'b1;
      if (batch_no == 9 || $urandom_range(0, 3) == 0) begin
        settle();
        write_reg(REG_KEY_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(REG_DESC_MASK, CFG_DATA_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 4) == 0)
          write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                    CFG_DATA_W'($urandom_range(0, 15)));
      end
      // one exactly full batch, one that overflows
      if (batch_no == 6)
        n_rows = MAX_ROWS;
      else if (batch_no == 25)
        n_rows = $urandom_range(MAX_ROWS + 1, MAX_ROWS + 6);
      else if ($urandom_range(0, 9) == 0)
        n_rows = 0;
      else
        n_rows = $urandom_range(1, 9);
      load_batch(n_rows, $urandom_range(0, 1) == 1);
      batch_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
